// ===== design/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and codes for the deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic KIND_FIRE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_HND = 1'b1;

    localparam logic REG_TICK_STEP   = 1'b0;
    localparam logic REG_FIRE_WINDOW = 1'b1;

    localparam int          CFG_W           = 20;
    localparam int          FIRE_CNT_W      = 5;
    localparam logic [4:0]  MAX_FIRES       = 5'd16;
    localparam logic [19:0] TICK_STEP_RST   = 20'd1;
    localparam logic [19:0] FIRE_WINDOW_RST = 20'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FIRE,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic fire;
        logic summary;
    } dtq_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic due;
        logic out_free;
    } dtq_stat_t;

endpackage

// ===== design/deadline_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_core
// flow: an accepted request starts a scan of all timer slots; each
// fired timer costs one further full slot scan, then a summary ends it
// a new request is taken only in idle, after the summary is issued;
// scans are paced by the one-entry-per-cycle read port of the timer store
// reset: aresetn low clears time and armed bits and restores config defaults; no clearing pass
// ----------------------------------------------------------------------------
module deadline_timer_queue_core #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [3:0]  s_timer_id,
    input  logic [31:0] s_delay_us,
    input  logic [7:0]  s_handler,
    input  logic [31:0] s_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [3:0]  m_fired_id,
    output logic [7:0]  m_fired_handler,
    output logic [31:0] m_fired_tag,
    output logic        m_status,
    output logic        m_next_valid,
    output logic [47:0] m_next_deadline,
    output logic        m_last
);

    dtq_pkg::dtq_cmd_t  cmd;
    dtq_pkg::dtq_stat_t stat;

    dtq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .cmd    (cmd),
        .stat   (stat)
    );

    dtq_datapath #(
        .NUM_TIMERS(NUM_TIMERS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_cmd          (s_cmd),
        .s_timer_id     (s_timer_id),
        .s_delay_us     (s_delay_us),
        .s_handler      (s_handler),
        .s_tag          (s_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_fired_id     (m_fired_id),
        .m_fired_handler(m_fired_handler),
        .m_fired_tag    (m_fired_tag),
        .m_status       (m_status),
        .m_next_valid   (m_next_valid),
        .m_next_deadline(m_next_deadline),
        .m_last         (m_last)
    );

endmodule

// ===== design/dtq_ram.sv =====
// ----------------------------------------------------------------------------
// dtq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dtq_datapath.sv =====
// ----------------------------------------------------------------------------
// dtq_datapath
// time base, config, armed bits, timer store, min scan and result register
// ----------------------------------------------------------------------------
module dtq_datapath #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dtq_pkg::dtq_cmd_t      cmd,
    output dtq_pkg::dtq_stat_t     stat,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [19:0]            cfg_data,
    input  logic [1:0]             s_cmd,
    input  logic [3:0]             s_timer_id,
    input  logic [31:0]            s_delay_us,
    input  logic [7:0]             s_handler,
    input  logic [31:0]            s_tag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_kind,
    output logic [3:0]             m_fired_id,
    output logic [7:0]             m_fired_handler,
    output logic [31:0]            m_fired_tag,
    output logic                   m_status,
    output logic                   m_next_valid,
    output logic [47:0]            m_next_deadline,
    output logic                   m_last
);

    localparam int IDX_W  = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
    localparam int SUM_W  = TIME_BITS + 1;
    localparam int ENT_W  = TIME_BITS + 40;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_TIMERS);

    // control state
    logic [TIME_BITS-1:0]        time_reg, time_next;
    logic [19:0]                 tick_step_reg, tick_step_next;
    logic [19:0]                 fire_window_reg, fire_window_next;
    logic [NUM_TIMERS-1:0]       armed_reg, armed_next;
    logic [CNT_W-1:0]            scan_addr_reg, scan_addr_next;
    logic                        rd_pipe_reg, rd_pipe_next;
    logic                        best_valid_reg, best_valid_next;
    logic [dtq_pkg::FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic                        out_valid_reg, out_valid_next;

    // payload
    logic [TIME_BITS-1:0]        limit_reg, limit_next;
    logic [TIME_BITS-1:0]        best_dl_reg, best_dl_next;
    logic [IDX_W-1:0]            best_id_reg, best_id_next;
    logic [7:0]                  best_hnd_reg, best_hnd_next;
    logic [31:0]                 best_tag_reg, best_tag_next;
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic                        rd_armed_reg, rd_armed_next;
    logic                        status_reg, status_next;
    logic                        kind_reg, kind_next;
    logic [3:0]                  fid_reg, fid_next;
    logic [7:0]                  fhnd_reg, fhnd_next;
    logic [31:0]                 ftag_reg, ftag_next;
    logic                        ostat_reg, ostat_next;
    logic                        nvalid_reg, nvalid_next;
    logic [47:0]                 ndl_reg, ndl_next;
    logic                        last_reg, last_next;

    logic [SUM_W-1:0]            tick_sum, dl_sum, lim_sum;
    logic [TIME_BITS-1:0]        tick_sat, dl_sat, lim_sat;
    logic                        id_ok;
    logic [IDX_W-1:0]            wr_idx;
    logic                        ram_we;
    logic [ENT_W-1:0]            ram_rdata;
    logic [TIME_BITS-1:0]        rd_dl;
    logic                        scan_issue;
    logic                        out_free;

    assign tick_sum = {1'b0, time_reg} + SUM_W'(tick_step_reg);
    assign dl_sum   = {1'b0, time_reg} + SUM_W'(s_delay_us);
    assign lim_sum  = {1'b0, time_reg} + SUM_W'(fire_window_reg);
    assign tick_sat = tick_sum[TIME_BITS] ? TIME_MAX : tick_sum[TIME_BITS-1:0];
    assign dl_sat   = dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];
    assign lim_sat  = lim_sum[TIME_BITS] ? TIME_MAX : lim_sum[TIME_BITS-1:0];

    assign id_ok  = {28'd0, s_timer_id} < 32'(NUM_TIMERS);
    assign wr_idx = IDX_W'(s_timer_id);
    assign ram_we = cmd.load && (s_cmd == dtq_pkg::CMD_SET) && (s_handler != 8'd0) && id_ok;

    assign scan_issue = cmd.scan && (scan_addr_reg != SCAN_END);
    assign rd_dl      = ram_rdata[ENT_W-1 -: TIME_BITS];
    assign out_free   = !out_valid_reg || m_ready;

    dtq_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_TIMERS)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wr_idx),
        .wdata({dl_sat, s_handler, s_tag}),
        .raddr(scan_addr_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    always_comb begin
        time_next        = time_reg;
        tick_step_next   = tick_step_reg;
        fire_window_next = fire_window_reg;
        armed_next       = armed_reg;
        scan_addr_next   = scan_addr_reg;
        rd_pipe_next     = scan_issue;
        best_valid_next  = best_valid_reg;
        fire_cnt_next    = fire_cnt_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        limit_next       = limit_reg;
        best_dl_next     = best_dl_reg;
        best_id_next     = best_id_reg;
        best_hnd_next    = best_hnd_reg;
        best_tag_next    = best_tag_reg;
        rd_idx_next      = scan_addr_reg[IDX_W-1:0];
        rd_armed_next    = armed_reg[scan_addr_reg[IDX_W-1:0]];
        status_next      = status_reg;
        kind_next        = kind_reg;
        fid_next         = fid_reg;
        fhnd_next        = fhnd_reg;
        ftag_next        = ftag_reg;
        ostat_next       = ostat_reg;
        nvalid_next      = nvalid_reg;
        ndl_next         = ndl_reg;
        last_next        = last_reg;

        if (cfg_we) begin
            if (cfg_index == dtq_pkg::REG_TICK_STEP) begin
                tick_step_next = cfg_data;
            end else begin
                fire_window_next = cfg_data;
            end
        end

        if (cmd.load) begin
            fire_cnt_next = '0;
            status_next   = dtq_pkg::STATUS_OK;
            case (s_cmd)
                dtq_pkg::CMD_TICK: begin
                    time_next = tick_sat;
                end
                dtq_pkg::CMD_SET: begin
                    if (s_handler == 8'd0) begin
                        status_next = dtq_pkg::STATUS_NO_HND;
                    end else if (id_ok) begin
                        armed_next[wr_idx] = 1'b1;
                    end
                end
                dtq_pkg::CMD_CLEAR: begin
                    if (id_ok) begin
                        armed_next[wr_idx] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.start) begin
            limit_next      = lim_sat;
            scan_addr_next  = '0;
            best_valid_next = 1'b0;
        end else begin
            if (scan_issue) begin
                scan_addr_next = scan_addr_reg + CNT_W'(1);
            end
            if (rd_pipe_reg && rd_armed_reg && (!best_valid_reg || rd_dl < best_dl_reg)) begin
                best_valid_next = 1'b1;
                best_dl_next    = rd_dl;
                best_id_next    = rd_idx_reg;
                best_hnd_next   = ram_rdata[39:32];
                best_tag_next   = ram_rdata[31:0];
            end
        end

        if (cmd.fire) begin
            armed_next[best_id_reg] = 1'b0;
            fire_cnt_next  = fire_cnt_reg + dtq_pkg::FIRE_CNT_W'(1);
            out_valid_next = 1'b1;
            kind_next      = dtq_pkg::KIND_FIRE;
            fid_next       = 4'(best_id_reg);
            fhnd_next      = best_hnd_reg;
            ftag_next      = best_tag_reg;
            ostat_next     = dtq_pkg::STATUS_OK;
            nvalid_next    = 1'b0;
            ndl_next       = '0;
            last_next      = 1'b0;
        end

        if (cmd.summary) begin
            out_valid_next = 1'b1;
            kind_next      = dtq_pkg::KIND_SUMMARY;
            fid_next       = '0;
            fhnd_next      = '0;
            ftag_next      = '0;
            ostat_next     = status_reg;
            nvalid_next    = best_valid_reg;
            ndl_next       = best_valid_reg ? 48'(best_dl_reg) : 48'd0;
            last_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg        <= '0;
            tick_step_reg   <= dtq_pkg::TICK_STEP_RST;
            fire_window_reg <= dtq_pkg::FIRE_WINDOW_RST;
            armed_reg       <= '0;
            scan_addr_reg   <= '0;
            rd_pipe_reg     <= 1'b0;
            best_valid_reg  <= 1'b0;
            fire_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            time_reg        <= time_next;
            tick_step_reg   <= tick_step_next;
            fire_window_reg <= fire_window_next;
            armed_reg       <= armed_next;
            scan_addr_reg   <= scan_addr_next;
            rd_pipe_reg     <= rd_pipe_next;
            best_valid_reg  <= best_valid_next;
            fire_cnt_reg    <= fire_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg    <= limit_next;
        best_dl_reg  <= best_dl_next;
        best_id_reg  <= best_id_next;
        best_hnd_reg <= best_hnd_next;
        best_tag_reg <= best_tag_next;
        rd_idx_reg   <= rd_idx_next;
        rd_armed_reg <= rd_armed_next;
        status_reg   <= status_next;
        kind_reg     <= kind_next;
        fid_reg      <= fid_next;
        fhnd_reg     <= fhnd_next;
        ftag_reg     <= ftag_next;
        ostat_reg    <= ostat_next;
        nvalid_reg   <= nvalid_next;
        ndl_reg      <= ndl_next;
        last_reg     <= last_next;
    end

    assign stat.scan_done = (scan_addr_reg == SCAN_END) && !rd_pipe_reg;
    assign stat.due       = best_valid_reg && (best_dl_reg <= limit_reg)
                            && (fire_cnt_reg != dtq_pkg::MAX_FIRES);
    assign stat.out_free  = out_free;

    assign m_valid         = out_valid_reg;
    assign m_kind          = kind_reg;
    assign m_fired_id      = fid_reg;
    assign m_fired_handler = fhnd_reg;
    assign m_fired_tag     = ftag_reg;
    assign m_status        = ostat_reg;
    assign m_next_valid    = nvalid_reg;
    assign m_next_deadline = ndl_reg;
    assign m_last          = last_reg;

`ifndef ASSERT_OFF
    a_fire_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= dtq_pkg::MAX_FIRES)
        else $error("fire count past limit");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fire || cmd.summary) |-> out_free)
        else $error("result register overwritten");

    a_fired_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fire |=> !armed_reg[$past(best_id_reg)])
        else $error("fired timer still armed");
`endif

endmodule

// ===== design/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl
// sequencer: command, scan, fire loop and summary
// ----------------------------------------------------------------------------
module dtq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output dtq_pkg::dtq_cmd_t   cmd,
    input  dtq_pkg::dtq_stat_t  stat
);

    dtq_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = dtq_pkg::ST_START;
                end
            end
            dtq_pkg::ST_START: begin
                state_next = dtq_pkg::ST_SCAN;
            end
            dtq_pkg::ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = stat.due ? dtq_pkg::ST_FIRE : dtq_pkg::ST_SUMMARY;
                end
            end
            dtq_pkg::ST_FIRE: begin
                if (stat.out_free) begin
                    state_next = dtq_pkg::ST_START;
                end
            end
            dtq_pkg::ST_SUMMARY: begin
                if (stat.out_free) begin
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            dtq_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            dtq_pkg::ST_START: begin
                cmd.start = 1'b1;
            end
            dtq_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            dtq_pkg::ST_FIRE: begin
                cmd.fire = stat.out_free;
            end
            dtq_pkg::ST_SUMMARY: begin
                cmd.summary = stat.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.start, cmd.scan, cmd.fire, cmd.summary}))
        else $error("conflicting datapath commands");
`endif

endmodule
